### rtl/char_lcd_controller_defines.svh
// Assertion macros used by the checker file.
// Each expects signals named clk and rst in the scope of use.
`ifndef CHAR_LCD_CONTROLLER_DEFINES_SVH
`define CHAR_LCD_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("char_lcd_controller: assertion failed");

// Next-cycle implication, disabled during reset.
`define CLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("char_lcd_controller: assertion failed");

`endif

### rtl/clc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

  localparam int LINE_LENGTH = 40;
  localparam int MEM_DEPTH   = 2 * LINE_LENGTH;
  localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Request types on the bus channel
  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_DATA = 2'd1,
    REQ_READ = 2'd2
  } req_kind_t;

  // Command byte codes and masks
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] MASK_HOME  = 8'hFE;
  localparam logic [7:0] CMD_HOME   = 8'h02;
  localparam logic [7:0] MASK_ENTRY = 8'hFC;
  localparam logic [7:0] CMD_ENTRY  = 8'h04;
  localparam logic [7:0] MASK_DISP  = 8'hF8;
  localparam logic [7:0] CMD_DISP   = 8'h08;
  localparam logic [7:0] MASK_FUNC  = 8'hE0;
  localparam logic [7:0] CMD_FUNC   = 8'h20;
  localparam int         BIT_SETADDR = 7;

  localparam logic [7:0] BLANK = 8'h20;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic execute;   // apply the request, issue memory read
    logic load_out;  // move the result into the output register
  } clc_cmd_t;

endpackage

`default_nettype wire

### rtl/clc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] bus_value;
  logic       read_line;
  logic [5:0] read_column;

  modport source (output valid, req_type, bus_value, read_line, read_column, input ready);
  modport sink   (input valid, req_type, bus_value, read_line, read_column, output ready);
endinterface

`default_nettype wire

### rtl/clc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_value;
  logic [6:0] cursor_now;
  logic       entry_increments;
  logic       display_shown;
  logic       cursor_shown;
  logic       blink_shown;

  modport source (output valid, cell_value, cursor_now, entry_increments, display_shown,
                  cursor_shown, blink_shown, input ready);
  modport sink   (input valid, cell_value, cursor_now, entry_increments, display_shown,
                  cursor_shown, blink_shown, output ready);
endinterface

`default_nettype wire

### rtl/clc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module clc_ctrl
  import clc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output clc_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t state;
  logic   load;

  // Load the result when the output register is empty or drains this cycle
  assign load = (state == S_FIN) && (!rsp_valid || rsp_ready);

  assign cmd.capture  = req_valid && req_ready;
  assign cmd.execute  = (state == S_EXEC);
  assign cmd.load_out = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the old one drains
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            state     <= S_EXEC;
            req_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (load) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/clc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module clc_datapath
  import clc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire clc_cmd_t   cmd,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] bus_value,
  input  wire logic       read_line,
  input  wire logic [5:0] read_column,
  output logic [7:0]      cell_value,
  output logic [6:0]      cursor_now,
  output logic            entry_increments,
  output logic            display_shown,
  output logic            cursor_shown,
  output logic            blink_shown
);

  // Captured request
  logic [1:0] type_q;
  logic [7:0] value_q;
  logic       line_q;
  logic [5:0] column_q;

  // Controller state
  logic [6:0] cursor;
  logic       incr;
  logic       disp_en;
  logic       curs_vis;
  logic       blink_en;

  // Display memory, valid bits stand for the space fill
  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] cell_ok;
  logic [7:0]           rd_data;
  logic                 rd_ok;

  logic              wr_in_range;
  logic [6:0]        wr_addr_full;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_in_range;
  logic [6:0]        rd_addr_full;
  logic [ADDR_W-1:0] rd_addr;
  logic              do_write;
  logic              do_clear;
  logic [7:0]        cell_sel;

  assign wr_in_range  = {1'b0, cursor[5:0]} < 7'(LINE_LENGTH);
  assign wr_addr_full = cursor[6] ? (7'(cursor[5:0]) + 7'(LINE_LENGTH)) : 7'(cursor[5:0]);
  assign wr_addr      = wr_in_range ? ADDR_W'(wr_addr_full) : '0;

  assign rd_in_range  = {1'b0, column_q} < 7'(LINE_LENGTH);
  assign rd_addr_full = line_q ? (7'(column_q) + 7'(LINE_LENGTH)) : 7'(column_q);
  assign rd_addr      = rd_in_range ? ADDR_W'(rd_addr_full) : '0;

  assign do_write = cmd.execute && (type_q == REQ_DATA) && wr_in_range;
  assign do_clear = cmd.execute && (type_q == REQ_CMD) && (value_q == CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_q   <= req_type;
      value_q  <= bus_value;
      line_q   <= read_line;
      column_q <= read_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      incr     <= 1'b1;
      disp_en  <= 1'b0;
      curs_vis <= 1'b0;
      blink_en <= 1'b0;
    end else if (cmd.execute) begin
      case (type_q)
        REQ_CMD: begin
          if (value_q == CMD_CLEAR) begin
            cursor <= '0;
          end else if ((value_q & MASK_HOME) == CMD_HOME) begin
            cursor <= '0;
          end else if ((value_q & MASK_ENTRY) == CMD_ENTRY) begin
            incr <= value_q[1];
          end else if ((value_q & MASK_DISP) == CMD_DISP) begin
            disp_en  <= value_q[2];
            curs_vis <= value_q[1];
            blink_en <= value_q[0];
          end else if ((value_q & MASK_FUNC) == CMD_FUNC) begin
            cursor <= cursor;
          end else if (value_q[BIT_SETADDR]) begin
            cursor <= value_q[6:0];
          end
        end
        REQ_DATA: begin
          cursor <= incr ? (cursor + 7'd1) : (cursor - 7'd1);
        end
        default: begin
          cursor <= cursor;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      cell_ok <= '0;
    end else if (do_write) begin
      cell_ok[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= value_q;
    end
    if (cmd.execute) begin
      rd_data <= mem[rd_addr];
      rd_ok   <= cell_ok[rd_addr];
    end
  end

  always_comb begin
    cell_sel = 8'h00;
    if (type_q == REQ_READ) begin
      cell_sel = (rd_in_range && rd_ok) ? rd_data : BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_value       <= cell_sel;
      cursor_now       <= cursor;
      entry_increments <= incr;
      display_shown    <= disp_en;
      cursor_shown     <= curs_vis;
      blink_shown      <= blink_en;
    end
  end

endmodule

`default_nettype wire

### rtl/char_lcd_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-line character LCD controller core. Each request on req is a command
// write, a data write or a read of one display cell; every request yields
// exactly one result on rsp carrying the cell (zero for writes, space for a
// column past the line) together with the cursor address and all flags as
// they stand after the request. A request passes from acceptance to result
// in steps: it is captured, then applied while the 80-byte display memory
// is read through its registered port, then loaded into the output
// register; the next request is taken the cycle after that, so no new
// request is taken before the last result is loaded. The output register
// holds a result while a new request is accepted; a stalled rsp holds the
// finishing request in its last step. A clear goes through the same steps:
// per-cell valid bits drop at once and unwritten cells read as space.
module char_lcd_controller
  import clc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  clc_req_if.sink   req,
  clc_rsp_if.source rsp
);

  clc_cmd_t cmd;

  // Sequence the request: capture, execute, load the result
  clc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Hold the display memory, cursor, flags and the output register
  clc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .req_type         (req.req_type),
    .bus_value        (req.bus_value),
    .read_line        (req.read_line),
    .read_column      (req.read_column),
    .cell_value       (rsp.cell_value),
    .cursor_now       (rsp.cursor_now),
    .entry_increments (rsp.entry_increments),
    .display_shown    (rsp.display_shown),
    .cursor_shown     (rsp.cursor_shown),
    .blink_shown      (rsp.blink_shown)
  );

endmodule

`default_nettype wire

### rtl/clc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_controller_defines.svh"

module clc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] cell_value,
  input wire logic [6:0] cursor_now
);

  logic req_take;
  assign req_take = req_valid && req_ready;

  // One request in work: ready stays low through execute and load
  `CLC_ASSERT_NEXT(a_busy_after_take, req_take, !req_ready ##1 !req_ready)

  // A result only appears as a request finishes
  `CLC_ASSERT_IMPL(a_result_from_work, $rose(rsp_valid), $past(!req_ready))

  // A stalled result holds
  `CLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(cell_value) && $stable(cursor_now))

endmodule

bind char_lcd_controller clc_checker u_clc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .cell_value (rsp.cell_value),
  .cursor_now (rsp.cursor_now)
);

`default_nettype wire
